// File: sv/jbt_pkg.sv
// shared constants and types of the json byte tokenizer
`default_nettype none
package jbt_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int OUT_W       = 24;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [OUT_W-1:0] LINE_MAX = {OUT_W{1'b1}};

  localparam logic [3:0] TT_LBRACE   = 4'd0;
  localparam logic [3:0] TT_RBRACE   = 4'd1;
  localparam logic [3:0] TT_LBRACKET = 4'd2;
  localparam logic [3:0] TT_RBRACKET = 4'd3;
  localparam logic [3:0] TT_COMMA    = 4'd4;
  localparam logic [3:0] TT_COLON    = 4'd5;
  localparam logic [3:0] TT_STRING   = 4'd6;
  localparam logic [3:0] TT_NUMBER   = 4'd7;
  localparam logic [3:0] TT_BOOL     = 4'd8;
  localparam logic [3:0] TT_NULL     = 4'd9;
  localparam logic [3:0] TT_EOF      = 4'd10;
  localparam logic [3:0] TT_ERROR    = 4'd11;

  localparam logic [1:0] EK_NONE    = 2'd0;
  localparam logic [1:0] EK_STRING  = 2'd1;
  localparam logic [1:0] EK_LITERAL = 2'd2;

  typedef struct packed {
    logic [3:0]       token_type;
    logic [OUT_W-1:0] start_offset;
    logic [OUT_W-1:0] token_length;
    logic [OUT_W-1:0] line_number;
    logic [1:0]       error_kind;
  } tok_t;

  // tokens caused by one input word
  typedef struct packed {
    tok_t tok0;
    tok_t tok1;
    logic two;
  } entry_t;

endpackage
`default_nettype wire

// File: sv/json_byte_tokenizer_top.sv
// top level of the streaming json byte tokenizer
// usage:
//   input channel: one word per byte of json text (in_data_byte), or an
//   end marker (in_end_of_input) that closes the document and resets state.
//   output channel: one word per token with type, start offset, length,
//   line number, error kind and a flag on the last token of its input byte.
// path: a token caused by an accepted byte is written into the token queue,
//   then loaded into the output register that drives out_valid.
// throughput: one byte per cycle while the token queue is not full; output
//   runs at one token per cycle while out_ready is high, so the two tokens
//   of one byte take two output words, absorbed by the four-entry queue.
// in_ready drops only when the token queue is full.
// reset: synchronous active low; lexer returns to idle, offset 0, line 1,
//   queue and output register empty.
// stall: when out_ready is low the output word holds, the queue fills and
//   then the input is stalled; no token is lost or repeated.
`default_nettype none
module json_byte_tokenizer_top import jbt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_end_of_input,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [3:0]            out_token_type,
  output logic [OUT_W-1:0]      out_start_offset,
  output logic [OUT_W-1:0]      out_token_length,
  output logic [OUT_W-1:0]      out_line_number,
  output logic [1:0]            out_error_kind,
  output logic                  out_last_of_run
);

  logic   push, full, pop, empty;
  entry_t push_data, head;

  jbt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_input (in_end_of_input),
    .push            (push),
    .push_data       (push_data),
    .fifo_full       (full)
  );

  jbt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  jbt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_type   (out_token_type),
    .out_start_offset (out_start_offset),
    .out_token_length (out_token_length),
    .out_line_number  (out_line_number),
    .out_error_kind   (out_error_kind),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
`default_nettype wire

// File: sv/jbt_front.sv
// front end: accepts bytes, tracks lexer state and classifies tokens
`default_nettype none
module jbt_front import jbt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_input,
  output logic            push,
  output entry_t          push_data,
  input  wire logic       fifo_full
);

  typedef enum logic [6:0] {
    M_IDLE   = 7'b0000001,
    M_NUMBER = 7'b0000010,
    M_STRING = 7'b0000100,
    M_ESCAPE = 7'b0001000,
    M_WORD   = 7'b0010000,
    M_ERROR  = 7'b0100000,
    M_DONE   = 7'b1000000
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OUT_W-1:0]       line_r, line_nxt;
  logic [7:0]             chars_r [5];
  logic [7:0]             chars_nxt [5];
  logic [2:0]             cnt_r, cnt_nxt;

  logic [7:0]             b;
  logic                   accept;
  logic [OFFSET_BITS-1:0] run_len;
  logic                   b_space, b_letter, b_digit, b_term;

  // idle lexing of the current byte
  logic                   idl_v;
  tok_t                   idl_tok;
  mode_t                  idl_mode;
  logic                   idl_set_start;
  logic [OFFSET_BITS-1:0] idl_start;
  logic                   idl_nl;
  logic                   idl_word;

  // word close
  logic                   w_true, w_false, w_null, w_ok;
  tok_t                   w_tok;

  logic                   cl_v, sec_v, use_idle;
  tok_t                   cl_tok, sec_tok;

  function automatic tok_t mk(logic [3:0] ty, logic [OFFSET_BITS-1:0] st,
                              logic [OFFSET_BITS-1:0] ln, logic [OUT_W-1:0] li,
                              logic [1:0] k);
    tok_t t;
    t.token_type   = ty;
    t.start_offset = OUT_W'(st);
    t.token_length = OUT_W'(ln);
    t.line_number  = li;
    t.error_kind   = k;
    return t;
  endfunction

  assign b        = in_data_byte;
  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;
  assign run_len  = off_r - start_r;

  assign b_space  = (b == 8'h20) || (b == 8'h09) || (b == 8'h0d) || (b == 8'h0a);
  assign b_letter = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  assign b_digit  = (b >= 8'h30 && b <= 8'h39);
  assign b_term   = (b == 8'h00) || b_space || (b == 8'h2c) || (b == 8'h5d)
                 || (b == 8'h7d);

  always_comb begin
    idl_v         = 1'b0;
    idl_tok       = mk(TT_EOF, off_r, OFFSET_BITS'(0), line_r, EK_NONE);
    idl_mode      = M_IDLE;
    idl_set_start = 1'b0;
    idl_start     = off_r;
    idl_nl        = 1'b0;
    idl_word      = 1'b0;
    unique case (b)
      8'h7b: begin idl_v = 1'b1;
        idl_tok = mk(TT_LBRACE, off_r, OFFSET_BITS'(1), line_r, EK_NONE); end
      8'h7d: begin idl_v = 1'b1;
        idl_tok = mk(TT_RBRACE, off_r, OFFSET_BITS'(1), line_r, EK_NONE); end
      8'h5b: begin idl_v = 1'b1;
        idl_tok = mk(TT_LBRACKET, off_r, OFFSET_BITS'(1), line_r, EK_NONE); end
      8'h5d: begin idl_v = 1'b1;
        idl_tok = mk(TT_RBRACKET, off_r, OFFSET_BITS'(1), line_r, EK_NONE); end
      8'h2c: begin idl_v = 1'b1;
        idl_tok = mk(TT_COMMA, off_r, OFFSET_BITS'(1), line_r, EK_NONE); end
      8'h3a: begin idl_v = 1'b1;
        idl_tok = mk(TT_COLON, off_r, OFFSET_BITS'(1), line_r, EK_NONE); end
      8'h00: begin
        idl_v    = 1'b1;
        idl_mode = M_DONE;
      end
      8'h22: begin
        idl_mode      = M_STRING;
        idl_set_start = 1'b1;
        idl_start     = off_r + OFFSET_BITS'(1);
      end
      default: begin
        if (b_space) begin
          idl_nl = (b == 8'h0a);
        end else if (b == 8'h2d || b_digit) begin
          idl_mode      = M_NUMBER;
          idl_set_start = 1'b1;
        end else if (b_letter) begin
          idl_mode      = M_WORD;
          idl_set_start = 1'b1;
          idl_word      = 1'b1;
        end else begin
          idl_v    = 1'b1;
          idl_mode = M_ERROR;
          idl_tok  = mk(TT_ERROR, off_r, OFFSET_BITS'(0), line_r, EK_LITERAL);
        end
      end
    endcase
  end

  always_comb begin
    w_true  = (cnt_r == 3'd4) && chars_r[0] == 8'h74 && chars_r[1] == 8'h72
           && chars_r[2] == 8'h75 && chars_r[3] == 8'h65;
    w_false = (cnt_r == 3'd5) && chars_r[0] == 8'h66 && chars_r[1] == 8'h61
           && chars_r[2] == 8'h6c && chars_r[3] == 8'h73 && chars_r[4] == 8'h65;
    w_null  = (cnt_r == 3'd4) && chars_r[0] == 8'h6e && chars_r[1] == 8'h75
           && chars_r[2] == 8'h6c && chars_r[3] == 8'h6c;
    w_ok    = w_true || w_false || w_null;
    if (w_true || w_false) begin
      w_tok = mk(TT_BOOL, start_r, run_len, line_r, EK_NONE);
    end else if (w_null) begin
      w_tok = mk(TT_NULL, start_r, run_len, line_r, EK_NONE);
    end else begin
      w_tok = mk(TT_ERROR, start_r, run_len, line_r, EK_LITERAL);
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    off_nxt   = off_r + OFFSET_BITS'(1);
    start_nxt = start_r;
    line_nxt  = line_r;
    for (int i = 0; i < 5; i++) chars_nxt[i] = chars_r[i];
    cnt_nxt   = cnt_r;
    cl_v      = 1'b0;
    cl_tok    = w_tok;
    sec_v     = 1'b0;
    sec_tok   = idl_tok;
    use_idle  = 1'b0;

    if (in_end_of_input) begin
      unique case (mode_r)
        M_NUMBER: begin
          cl_v   = 1'b1;
          cl_tok = mk(TT_NUMBER, start_r, run_len, line_r, EK_NONE);
        end
        M_WORD: cl_v = 1'b1;
        M_STRING, M_ESCAPE: begin
          cl_v   = 1'b1;
          cl_tok = mk(TT_ERROR, start_r, run_len, line_r, EK_STRING);
        end
        default: cl_v = 1'b0;
      endcase
      sec_v     = 1'b1;
      sec_tok   = mk(TT_EOF, off_r, OFFSET_BITS'(0), line_r, EK_NONE);
      mode_nxt  = M_IDLE;
      off_nxt   = '0;
      start_nxt = '0;
      line_nxt  = OUT_W'(1);
      for (int i = 0; i < 5; i++) chars_nxt[i] = 8'h00;
      cnt_nxt   = 3'd0;
    end else begin
      unique case (mode_r)
        M_IDLE: use_idle = 1'b1;
        M_NUMBER: begin
          if (b_term) begin
            cl_v     = 1'b1;
            cl_tok   = mk(TT_NUMBER, start_r, run_len, line_r, EK_NONE);
            use_idle = 1'b1;
          end
        end
        M_STRING: begin
          if (b == 8'h00) begin
            cl_v     = 1'b1;
            cl_tok   = mk(TT_ERROR, start_r, run_len, line_r, EK_STRING);
            mode_nxt = M_ERROR;
          end else if (b == 8'h22) begin
            cl_v     = 1'b1;
            cl_tok   = mk(TT_STRING, start_r, run_len, line_r, EK_NONE);
            mode_nxt = M_IDLE;
          end else if (b == 8'h5c) begin
            mode_nxt = M_ESCAPE;
          end
        end
        M_ESCAPE: begin
          if (b == 8'h00) begin
            cl_v     = 1'b1;
            cl_tok   = mk(TT_ERROR, start_r, run_len, line_r, EK_STRING);
            mode_nxt = M_ERROR;
          end else begin
            mode_nxt = M_STRING;
          end
        end
        M_WORD: begin
          if (b_letter) begin
            if (cnt_r < 3'd5) begin
              for (int i = 0; i < 5; i++) begin
                if (cnt_r == 3'(i)) chars_nxt[i] = b;
              end
              cnt_nxt = cnt_r + 3'd1;
            end else begin
              cnt_nxt = 3'd6;
            end
          end else begin
            cl_v = 1'b1;
            if (w_ok) begin
              use_idle = 1'b1;
            end else begin
              mode_nxt = M_ERROR;
            end
          end
        end
        default: mode_nxt = mode_r;
      endcase

      if (use_idle) begin
        mode_nxt = idl_mode;
        sec_v    = idl_v;
        if (idl_set_start) start_nxt = idl_start;
        if (idl_nl && line_r != LINE_MAX) line_nxt = line_r + OUT_W'(1);
        if (idl_word) begin
          chars_nxt[0] = b;
          cnt_nxt      = 3'd1;
        end
      end
    end
  end

  assign push           = accept && (cl_v || sec_v);
  assign push_data.tok0 = cl_v ? cl_tok : sec_tok;
  assign push_data.tok1 = sec_tok;
  assign push_data.two  = cl_v && sec_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      off_r   <= '0;
      start_r <= '0;
      line_r  <= OUT_W'(1);
      for (int i = 0; i < 5; i++) chars_r[i] <= 8'h00;
      cnt_r   <= 3'd0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      off_r   <= off_nxt;
      start_r <= start_nxt;
      line_r  <= line_nxt;
      for (int i = 0; i < 5; i++) chars_r[i] <= chars_nxt[i];
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/jbt_fifo.sv
// short queue of token words between front and back end
`default_nettype none
module jbt_fifo import jbt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_data,
  output logic        full,
  input  wire logic   pop,
  output entry_t      head,
  output logic        empty
);

  entry_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_r, rd_r;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (FIFO_AW+1)'(1);
    if (pop && !push) cnt_nxt = cnt_r - (FIFO_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + FIFO_AW'(1);
      if (pop)  rd_r <= rd_r + FIFO_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/jbt_back.sv
// back end: splits queued words into single tokens on the output register
`default_nettype none
module jbt_back import jbt_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire entry_t       head,
  input  wire logic         empty,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [3:0]        out_token_type,
  output logic [OUT_W-1:0]  out_start_offset,
  output logic [OUT_W-1:0]  out_token_length,
  output logic [OUT_W-1:0]  out_line_number,
  output logic [1:0]        out_error_kind,
  output logic              out_last_of_run
);

  logic  valid_r;
  logic  idx_r, idx_nxt;
  tok_t  tok_r, sel;
  logic  last_r, last;
  logic  load;

  assign load = (!valid_r || out_ready) && !empty;
  assign sel  = idx_r ? head.tok1 : head.tok0;
  assign last = !head.two || idx_r;
  assign pop  = load && last;

  always_comb begin
    idx_nxt = idx_r;
    if (load) idx_nxt = !last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= sel;
      last_r <= last;
    end
  end

  assign out_valid        = valid_r;
  assign out_token_type   = tok_r.token_type;
  assign out_start_offset = tok_r.start_offset;
  assign out_token_length = tok_r.token_length;
  assign out_line_number  = tok_r.line_number;
  assign out_error_kind   = tok_r.error_kind;
  assign out_last_of_run  = last_r;

endmodule
`default_nettype wire
